>>> sv/mic_slot_select_dc_blocker_unit_assert.svh
// Assertion macros for the mic slot select DC blocker datapath.
`ifndef MIC_SLOT_SELECT_DC_BLOCKER_UNIT_ASSERT_SVH
`define MIC_SLOT_SELECT_DC_BLOCKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MSDC_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MSDC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> sv/msdc_pkg.sv
// Package: constants, state encoding and control structs of the slot select DC blocker.
`default_nettype none

package msdc_pkg;

	localparam int SAMPLE_W           = 32;
	localparam int PCM_W              = 16;
	localparam int ACC_W              = 25;
	localparam int BUF_DEPTH          = 64;
	localparam int FIRST_CHUNK_FRAMES = 64;
	localparam int ADDR_W             = $clog2(BUF_DEPTH);
	localparam int CNT_W              = ADDR_W + 1;
	localparam int FRAME_W            = 2 * PCM_W;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PEAK,
		ST_DECIDE,
		ST_READ,
		ST_DECAY,
		ST_FILT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic peak_upd;
		logic decide;
		logic decay_ld;
		logic filt_ld;
		logic idx_inc;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic decided;
		logic decide_now;
		logic draining;
		logic last_drain;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> sv/msdc_in_if.sv
// Interface: input frame channel (valid/ready plus stereo sample payload).
`default_nettype none

interface msdc_in_if;
	import msdc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       chunk_end;

	modport source (output valid, output left_sample, output right_sample,
		output chunk_end, input ready);
	modport sink (input valid, input left_sample, input right_sample,
		input chunk_end, output ready);
endinterface

`default_nettype wire

>>> sv/msdc_out_if.sv
// Interface: output result channel (valid/ready plus PCM payload).
`default_nettype none

interface msdc_out_if;
	import msdc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [PCM_W-1:0] pcm_sample;
	logic                    right_chosen;
	logic                    last;

	modport source (output valid, output pcm_sample, output right_chosen,
		output last, input ready);
	modport sink (input valid, input pcm_sample, input right_chosen,
		input last, output ready);
endinterface

`default_nettype wire

>>> sv/msdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/msdc_ctrl.sv
// Sequencer: steps each transaction through store, decide, drain and filter.
`default_nettype none

module msdc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output msdc_pkg::cmd_t     cmd,
	input  wire msdc_pkg::sts_t sts
);
	import msdc_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.decided ? ST_DECAY : ST_PEAK;
				end
			end
			ST_PEAK: begin
				state_d = sts.decide_now ? ST_DECIDE : ST_IDLE;
			end
			ST_DECIDE: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_DECAY;
			end
			ST_DECAY: begin
				state_d = ST_FILT;
			end
			ST_FILT: begin
				if (sts.out_free) begin
					state_d = (sts.draining && !sts.last_drain) ? ST_READ : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_PEAK: begin
				cmd.peak_upd = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			ST_READ: begin
				// RAM read of the current drain index is in flight
			end
			ST_DECAY: begin
				cmd.decay_ld = 1'b1;
			end
			ST_FILT: begin
				cmd.filt_ld = sts.out_free;
				cmd.idx_inc = sts.out_free && sts.draining && !sts.last_drain;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/msdc_dp.sv
// Datapath: peak tracking, frame buffer, DC blocking filter and output register.
`default_nettype none
`include "mic_slot_select_dc_blocker_unit_assert.svh"

module msdc_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [msdc_pkg::SAMPLE_W-1:0] left_sample,
	input  wire logic signed [msdc_pkg::SAMPLE_W-1:0] right_sample,
	input  wire logic                                chunk_end,
	input  wire logic                                out_ready,
	input  wire msdc_pkg::cmd_t                      cmd,
	output msdc_pkg::sts_t                           sts,
	output logic                                     out_valid,
	output logic signed [msdc_pkg::PCM_W-1:0]        pcm_sample,
	output logic                                     right_chosen,
	output logic                                     last
);
	import msdc_pkg::*;

	// Captured transaction
	logic [SAMPLE_W-1:0]     in_left_q;
	logic [SAMPLE_W-1:0]     in_right_q;
	logic                    in_end_q;

	// Selection state
	logic [SAMPLE_W-1:0]     pk_l_q;
	logic [SAMPLE_W-1:0]     pk_r_q;
	logic [CNT_W-1:0]        count_q;
	logic [ADDR_W-1:0]       idx_q;
	logic                    decided_q;
	logic                    right_sel_q;
	logic                    drain_q;

	// Filter state
	logic signed [PCM_W-1:0] x_q;
	logic signed [ACC_W-1:0] decay_q;
	logic signed [PCM_W-1:0] prev_in_q;
	logic signed [ACC_W-1:0] prev_out_q;

	// Output register
	logic                    out_valid_q;
	logic signed [PCM_W-1:0] pcm_q;
	logic                    right_q;
	logic                    last_q;

	logic [SAMPLE_W-1:0]     mag_l;
	logic [SAMPLE_W-1:0]     mag_r;
	logic [FRAME_W-1:0]      rd_frame;
	logic signed [PCM_W-1:0] x_sel;
	logic signed [30:0]      prod;
	logic signed [30:0]      prod_adj;
	logic signed [ACC_W-1:0] y_sum;
	logic signed [PCM_W-1:0] pcm_sat;
	logic                    out_free;
	logic                    last_drain;
	logic                    decide_now;

	// Frame buffer: left upper half in high bits, right upper half in low bits
	msdc_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (BUF_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (cmd.peak_upd),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({in_left_q[SAMPLE_W-1 -: PCM_W], in_right_q[SAMPLE_W-1 -: PCM_W]}),
		.raddr (idx_q),
		.rdata (rd_frame)
	);

	// Magnitudes; the most negative input maps to 2^31
	assign mag_l = in_left_q[SAMPLE_W-1] ? (SAMPLE_W'(0) - in_left_q) : in_left_q;
	assign mag_r = in_right_q[SAMPLE_W-1] ? (SAMPLE_W'(0) - in_right_q) : in_right_q;

	assign decide_now = in_end_q || ((count_q + CNT_W'(1)) == CNT_W'(FIRST_CHUNK_FRAMES));
	assign last_drain = ({1'b0, idx_q} + CNT_W'(1)) == count_q;
	assign out_free   = !out_valid_q || out_ready;

	// Filter input: buffered frame while draining, else the live frame
	always_comb begin
		if (drain_q) begin
			x_sel = right_sel_q ? $signed(rd_frame[PCM_W-1:0])
				: $signed(rd_frame[FRAME_W-1 -: PCM_W]);
		end else begin
			x_sel = right_sel_q ? $signed(in_right_q[SAMPLE_W-1 -: PCM_W])
				: $signed(in_left_q[SAMPLE_W-1 -: PCM_W]);
		end
	end

	// Decay term: 63*y_prev/64 truncated toward zero
	assign prod     = $signed({prev_out_q, 6'b0}) - 31'(prev_out_q);
	assign prod_adj = prod + (prod[30] ? 31'sd63 : 31'sd0);

	// Filter sum, doubled and saturated
	assign y_sum = ACC_W'(x_q) - ACC_W'(prev_in_q) + decay_q;

	always_comb begin
		if (y_sum > 25'sd16383) begin
			pcm_sat = 16'sh7FFF;
		end else if (y_sum < -25'sd16384) begin
			pcm_sat = 16'sh8000;
		end else begin
			pcm_sat = {y_sum[PCM_W-2:0], 1'b0};
		end
	end

	// Captured payload, filter operands and output payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_left_q  <= left_sample;
			in_right_q <= right_sample;
			in_end_q   <= chunk_end;
		end
		if (cmd.decay_ld) begin
			x_q     <= x_sel;
			decay_q <= ACC_W'(prod_adj >>> 6);
		end
		if (cmd.filt_ld) begin
			pcm_q   <= pcm_sat;
			right_q <= right_sel_q;
			last_q  <= drain_q ? last_drain : 1'b1;
		end
	end

	// Selection, filter and output valid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_l_q       <= '0;
			pk_r_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			decided_q    <= 1'b0;
			right_sel_q  <= 1'b0;
			drain_q      <= 1'b0;
			prev_in_q    <= '0;
			prev_out_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.peak_upd) begin
				if (mag_l > pk_l_q) begin
					pk_l_q <= mag_l;
				end
				if (mag_r > pk_r_q) begin
					pk_r_q <= mag_r;
				end
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.decide) begin
				decided_q   <= 1'b1;
				right_sel_q <= pk_r_q > pk_l_q;
				drain_q     <= 1'b1;
				idx_q       <= '0;
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			if (cmd.filt_ld) begin
				prev_in_q  <= x_q;
				prev_out_q <= y_sum;
				if (drain_q && last_drain) begin
					drain_q <= 1'b0;
				end
			end
			if (cmd.filt_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.decided    = decided_q;
	assign sts.decide_now = decide_now;
	assign sts.draining   = drain_q;
	assign sts.last_drain = last_drain;
	assign sts.out_free   = out_free;

	assign out_valid    = out_valid_q;
	assign pcm_sample   = pcm_q;
	assign right_chosen = right_q;
	assign last         = last_q;

	`MSDC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(FIRST_CHUNK_FRAMES), "frame count overran")
	`MSDC_ASSERT_NEXT(a_decided_sticky, decided_q, decided_q, "slot decision was lost")
	`MSDC_ASSERT_NEXT(a_count_frozen, decided_q, $stable(count_q), "buffer count moved after decision")
	`MSDC_ASSERT_NOW(a_no_overwrite, cmd.filt_ld, out_free, "result loaded over a pending one")
	`MSDC_ASSERT_NOW(a_drain_decided, drain_q, decided_q, "draining before a decision")

endmodule

`default_nettype wire

>>> sv/mic_slot_select_dc_blocker_unit.sv
// Top level: microphone slot selector with DC blocking high-pass filter.
`default_nettype none

// Stereo 32-bit frames come in on in_ch; filtered 16-bit PCM goes out on out_ch.
// Until a slot is chosen, each frame is captured, then given a peak update and
// buffer write, and gives no result. The frame that closes the first chunk
// (chunk_end, or the buffer reaching its frame limit) adds a decision step,
// then the buffer drains one stored frame at a time (RAM read, decay term,
// filter sum), all with right_chosen fixed and last on the final one. After that
// every frame goes through capture, decay term, filter sum into the output
// register. The steps follow from the sequencer sharing one filter and the
// buffer's single registered read port; a stalled output holds the filter step.
// The buffer needs no clear after reset: only written entries are ever read.
module mic_slot_select_dc_blocker_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	msdc_in_if.sink   in_ch,
	msdc_out_if.source out_ch
);
	import msdc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	msdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	msdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.left_sample  (in_ch.left_sample),
		.right_sample (in_ch.right_sample),
		.chunk_end    (in_ch.chunk_end),
		.out_ready    (out_ch.ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_ch.valid),
		.pcm_sample   (out_ch.pcm_sample),
		.right_chosen (out_ch.right_chosen),
		.last         (out_ch.last)
	);

endmodule

`default_nettype wire
